>>> design/soilevap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil evaporation package
// Item types, sequencer states, constants and the saturating arithmetic that
// the soil evaporation block uses.
// ----------------------------------------------------------------------------
package soilevap_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   localparam logic [DATA_WIDTH-1:0] DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] DW_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                         first_layer;
      logic                         last_layer;
      logic signed [DATA_WIDTH-1:0] potential_et;
      logic signed [DATA_WIDTH-1:0] interception_et;
      logic signed [DATA_WIDTH-1:0] depression_et;
      logic signed [DATA_WIDTH-1:0] plant_et;
      logic signed [DATA_WIDTH-1:0] soil_temp;
      logic signed [DATA_WIDTH-1:0] layer_water;
      logic signed [DATA_WIDTH-1:0] field_capacity;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] new_water;
      logic signed [DATA_WIDTH-1:0] layer_et;
      logic signed [DATA_WIDTH-1:0] cell_et;
      logic                         cell_done;
      logic                         negative_water;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEF1,
      ST_DEF2,
      ST_DEF3,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   // a - b, clamped to the signed range
   function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] wide;
      wide = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      if (wide[DATA_WIDTH] != wide[DATA_WIDTH-1]) begin
         return wide[DATA_WIDTH] ? DW_MIN : DW_MAX;
      end
      return wide[DATA_WIDTH-1:0];
   endfunction

   // a + b, clamped to the signed range
   function automatic logic signed [DATA_WIDTH-1:0] sat_add(
      input logic signed [DATA_WIDTH-1:0] a,
      input logic signed [DATA_WIDTH-1:0] b
   );
      logic [DATA_WIDTH:0] wide;
      wide = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      if (wide[DATA_WIDTH] != wide[DATA_WIDTH-1]) begin
         return wide[DATA_WIDTH] ? DW_MIN : DW_MAX;
      end
      return wide[DATA_WIDTH-1:0];
   endfunction

endpackage

>>> design/soil_evaporation_linear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil evaporation, linear in layer water
// Takes one soil layer per item and gives the layer's evaporation, its new
// water, the running cell total and a negative water flag.
// ----------------------------------------------------------------------------
// One item is handled at a time; req_stall stays high from acceptance until
// the result is loaded into the output register. An item that opens a cell
// first builds the deficit by one saturating subtract a cycle. A division
// follows when the cell is not frozen, the deficit is positive and the layer
// water is non-negative but below field capacity; the radix-2 divider forms
// deficit * water / capacity, one deficit bit a cycle. The next item may be
// accepted while a result is still held on the rsp side. The frozen threshold
// register is written through csr_wr_en and csr_wr_data; the user must do so
// only between items, as the block itself does not enforce it.
module soil_evaporation_linear (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  soilevap_pkg::req_type                     req_item,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output soilevap_pkg::rsp_type                     rsp_item,
   input  logic                                      csr_wr_en,
   input  logic signed [soilevap_pkg::DATA_WIDTH-1:0] csr_wr_data
);

   localparam int DW = soilevap_pkg::DATA_WIDTH;
   localparam int CW = soilevap_pkg::CNT_WIDTH;

   soilevap_pkg::state_type state_ff, state_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   soilevap_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic signed [DW-1:0] thresh_ff, thresh_in;
   logic signed [DW-1:0] deficit_ff, deficit_in;
   logic signed [DW-1:0] total_ff, total_in;
   logic                 frozen_ff, frozen_in;

   logic                 last_ff, last_in;
   logic                 active_ff, active_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] inter_ff, inter_in;
   logic signed [DW-1:0] dep_ff, dep_in;
   logic signed [DW-1:0] plant_ff, plant_in;
   logic signed [DW-1:0] water_ff, water_in;
   logic signed [DW-1:0] cap_ff, cap_in;
   logic signed [DW-1:0] et_ff, et_in;

   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        quo_ff, quo_in;
   logic [DW-1:0]        dsh_ff, dsh_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   // shared saturating subtractor
   logic signed [DW-1:0] sub_a, sub_b, sub_res;

   // divider step
   logic [DW:0]          div_sum;
   logic [DW:0]          div_cap1, div_cap2;
   logic [1:0]           div_k;
   logic [DW:0]          div_rem;
   logic [DW-1:0]        div_quo;

   // result forming
   logic signed [DW-1:0] fin_et, fin_water, fin_total;

   assign req_stall = (state_ff != soilevap_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign sub_res = soilevap_pkg::sat_sub(sub_a, sub_b);

   always_comb begin
      div_sum  = {rem_ff, 1'b0} + (dsh_ff[DW-1] ? {1'b0, water_ff} : {(DW+1){1'b0}});
      div_cap1 = {1'b0, cap_ff};
      div_cap2 = {cap_ff, 1'b0};
      if (div_sum >= div_cap2) begin
         div_k   = 2'd2;
         div_rem = div_sum - div_cap2;
      end else if (div_sum >= div_cap1) begin
         div_k   = 2'd1;
         div_rem = div_sum - div_cap1;
      end else begin
         div_k   = 2'd0;
         div_rem = div_sum;
      end
      div_quo = {quo_ff[DW-2:0], 1'b0} + {{(DW-2){1'b0}}, div_k};
   end

   // clip to the water present (negative water gives negative ET); an inactive layer keeps its water
   always_comb begin
      if (!active_ff) begin
         fin_et    = '0;
         fin_water = water_ff;
      end else if (et_ff > water_ff) begin
         fin_et    = water_ff;
         fin_water = '0;
      end else begin
         fin_et    = et_ff;
         fin_water = water_ff - et_ff;
      end
      fin_total = soilevap_pkg::sat_add(total_ff, fin_et);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      deficit_in   = deficit_ff;
      total_in     = total_ff;
      frozen_in    = frozen_ff;
      last_in      = last_ff;
      active_in    = active_ff;
      acc_in       = acc_ff;
      inter_in     = inter_ff;
      dep_in       = dep_ff;
      plant_in     = plant_ff;
      water_in     = water_ff;
      cap_in       = cap_ff;
      et_in        = et_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dsh_in       = dsh_ff;
      cnt_in       = cnt_ff;
      sub_a        = acc_ff;
      sub_b        = inter_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         soilevap_pkg::ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_item.last_layer;
               water_in = req_item.layer_water;
               cap_in   = req_item.field_capacity;
               acc_in   = req_item.potential_et;
               inter_in = req_item.interception_et;
               dep_in   = req_item.depression_et;
               plant_in = req_item.plant_et;
               if (req_item.first_layer) begin
                  frozen_in = (req_item.soil_temp <= thresh_ff);
                  total_in  = '0;
                  state_in  = soilevap_pkg::ST_DEF1;
               end else begin
                  state_in = soilevap_pkg::ST_EVAL;
               end
            end
         end
         soilevap_pkg::ST_DEF1: begin
            sub_b    = inter_ff;
            acc_in   = sub_res;
            state_in = soilevap_pkg::ST_DEF2;
         end
         soilevap_pkg::ST_DEF2: begin
            sub_b    = dep_ff;
            acc_in   = sub_res;
            state_in = soilevap_pkg::ST_DEF3;
         end
         soilevap_pkg::ST_DEF3: begin
            sub_b      = plant_ff;
            deficit_in = sub_res;
            state_in   = soilevap_pkg::ST_EVAL;
         end
         soilevap_pkg::ST_EVAL: begin
            et_in = '0;
            if (frozen_ff || deficit_ff[DW-1] || deficit_ff == '0) begin
               active_in = 1'b0;
               state_in  = soilevap_pkg::ST_DONE;
            end else begin
               active_in = 1'b1;
               if (water_ff >= cap_ff) begin
                  et_in    = deficit_ff;
                  state_in = soilevap_pkg::ST_DONE;
               end else if (!water_ff[DW-1]) begin
                  rem_in   = '0;
                  quo_in   = '0;
                  dsh_in   = deficit_ff;
                  cnt_in   = CW'(DW - 1);
                  state_in = soilevap_pkg::ST_DIV;
               end else begin
                  state_in = soilevap_pkg::ST_DONE;
               end
            end
         end
         soilevap_pkg::ST_DIV: begin
            // one deficit bit a cycle, remainder kept below capacity
            rem_in = div_rem[DW-1:0];
            quo_in = div_quo;
            dsh_in = {dsh_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               et_in    = div_quo;
               state_in = soilevap_pkg::ST_DONE;
            end
         end
         soilevap_pkg::ST_DONE: begin
            sub_a = deficit_ff;
            sub_b = fin_et;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.new_water      = fin_water;
               rsp_item_in.layer_et       = fin_et;
               rsp_item_in.cell_et        = active_ff ? fin_total : total_ff;
               rsp_item_in.cell_done      = last_ff;
               rsp_item_in.negative_water = fin_water[DW-1];
               if (active_ff) begin
                  deficit_in = sub_res;
                  total_in   = fin_total;
               end
               state_in = soilevap_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = soilevap_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= soilevap_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= '0;
         deficit_ff   <= '0;
         total_ff     <= '0;
         frozen_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         deficit_ff   <= deficit_in;
         total_ff     <= total_in;
         frozen_ff    <= frozen_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      last_ff     <= last_in;
      active_ff   <= active_in;
      acc_ff      <= acc_in;
      inter_ff    <= inter_in;
      dep_ff      <= dep_in;
      plant_ff    <= plant_in;
      water_ff    <= water_in;
      cap_ff      <= cap_in;
      et_ff       <= et_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsh_ff      <= dsh_in;
      cnt_ff      <= cnt_in;
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Soil evaporation block testbench
// Feeds soil layers cell by cell and checks every result against a local
// prediction of deficit, clipping and cell total. Both channels idle at
// random, the frozen threshold is rewritten between phases, and one long
// output hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     DW           = soilevap_pkg::DATA_WIDTH;
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     ITEM_TARGET  = 550;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     DRAIN_CYCLES = 45;
   localparam longint SAT_HI       = (longint'(1) <<< (DW - 1)) - 1;
   localparam longint SAT_LO       = -SAT_HI - 1;
   localparam logic signed [DW-1:0] MM   = 65536;
   localparam logic signed [DW-1:0] VMAX = soilevap_pkg::DW_MAX;
   localparam logic signed [DW-1:0] VMIN = soilevap_pkg::DW_MIN;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;
   typedef enum {CELL_WELL, CELL_BROKEN, CELL_NOISE} cell_kind_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   soilevap_pkg::req_type req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   soilevap_pkg::rsp_type rsp_item;
   logic                  csr_wr_en   = 1'b0;
   logic signed [DW-1:0]  csr_wr_data = '0;

   // predicted block state
   longint                frost_threshold = 0;
   longint                deficit_left    = 0;
   longint                cell_sum        = 0;
   bit                    cell_is_frozen  = 1'b0;
   soilevap_pkg::rsp_type pending_layers[$];
   soilevap_pkg::rsp_type want_rsp;

   stall_mode_type stall_mode   = STALL_NONE;
   int unsigned    stall_phase  = 0;
   int             hold_left    = 0;
   bit             hold_request = 1'b0;
   int             gap_max      = 0;
   int             burst_left   = 0;
   int             items_sent   = 0;
   int             failures     = 0;
   int             cycle_count  = 0;

   soil_evaporation_linear u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: a long hold-off on request, otherwise the current stall pattern
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            default:      rsp_stall <= ((stall_phase % 13) < 5);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_layers.size() == 0) begin
            $error("result with no item outstanding");
            failures++;
         end else begin
            want_rsp = pending_layers.pop_front();
            if (rsp_item.new_water !== want_rsp.new_water) begin
               $error("new_water: expected %0d, got %0d",
                      want_rsp.new_water, rsp_item.new_water);
               failures++;
            end
            if (rsp_item.layer_et !== want_rsp.layer_et) begin
               $error("layer_et: expected %0d, got %0d",
                      want_rsp.layer_et, rsp_item.layer_et);
               failures++;
            end
            if (rsp_item.cell_et !== want_rsp.cell_et) begin
               $error("cell_et: expected %0d, got %0d",
                      want_rsp.cell_et, rsp_item.cell_et);
               failures++;
            end
            if (rsp_item.cell_done !== want_rsp.cell_done) begin
               $error("cell_done: expected %0d, got %0d",
                      want_rsp.cell_done, rsp_item.cell_done);
               failures++;
            end
            if (rsp_item.negative_water !== want_rsp.negative_water) begin
               $error("negative_water: expected %0d, got %0d",
                      want_rsp.negative_water, rsp_item.negative_water);
               failures++;
            end
         end
      end
   end

   function automatic longint clamp_dw(input longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   // advance the predicted state by one layer and return its result
   function automatic soilevap_pkg::rsp_type evaporate_layer(
      input soilevap_pkg::req_type layer
   );
      longint                water;
      longint                cap;
      longint                amount;
      longint                left;
      soilevap_pkg::rsp_type r;
      water  = $signed(layer.layer_water);
      cap    = $signed(layer.field_capacity);
      left   = water;
      amount = 0;
      if (layer.first_layer) begin
         deficit_left = $signed(layer.potential_et);
         deficit_left = clamp_dw(deficit_left - $signed(layer.interception_et));
         deficit_left = clamp_dw(deficit_left - $signed(layer.depression_et));
         deficit_left = clamp_dw(deficit_left - $signed(layer.plant_et));
         cell_sum       = 0;
         cell_is_frozen = ($signed(layer.soil_temp) <= frost_threshold);
      end
      if (!cell_is_frozen && deficit_left > 0) begin
         if (water >= cap)
            amount = deficit_left;
         else if (water >= 0)
            amount = deficit_left * water / cap;
         else
            amount = 0;
         // clip to the water present; negative water thus gives negative ET
         if (amount > water) begin
            amount = water;
            left   = 0;
         end else begin
            left = water - amount;
         end
         deficit_left = clamp_dw(deficit_left - amount);
         cell_sum     = clamp_dw(cell_sum + amount);
      end
      r.new_water      = left[DW-1:0];
      r.layer_et       = amount[DW-1:0];
      r.cell_et        = cell_sum[DW-1:0];
      r.cell_done      = layer.last_layer;
      r.negative_water = (left < 0);
      return r;
   endfunction

   function automatic soilevap_pkg::req_type make_layer(
      input bit first, last,
      input logic signed [DW-1:0] pot, icpt, dep, plant, temp, water, cap
   );
      soilevap_pkg::req_type layer;
      layer.first_layer     = first;
      layer.last_layer      = last;
      layer.potential_et    = pot;
      layer.interception_et = icpt;
      layer.depression_et   = dep;
      layer.plant_et        = plant;
      layer.soil_temp       = temp;
      layer.layer_water     = water;
      layer.field_capacity  = cap;
      return layer;
   endfunction

   function automatic logic signed [DW-1:0] pick_amount(input int unsigned typical);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0:       return VMAX;
               1:       return VMIN;
               2:       return 0;
               3:       return -1;
               default: return 1;
            endcase
         end
         2:       return -$signed($urandom_range(0, 5 * MM));
         default: return $urandom_range(0, typical);
      endcase
   endfunction

   function automatic logic signed [DW-1:0] pick_temp();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, 60 * MM)) - 20 * MM;
   endfunction

   // drop valid after a burst and idle for a random gap
   task automatic pace_sender();
      if (gap_max == 0) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(0, 7);
      end
   endtask

   task automatic send_layer(input soilevap_pkg::req_type layer);
      req_item  <= layer;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_layers.push_back(evaporate_layer(layer));
      items_sent++;
      pace_sender();
   endtask

   // wait until every result is out and the block has gone quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_layers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [DW-1:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      frost_threshold  = value;
   endtask

   task automatic random_cell(input cell_kind_type kind);
      int unsigned           layers;
      soilevap_pkg::req_type layer;
      layers = (kind == CELL_NOISE) ? 1 : $urandom_range(1, 6);
      for (int i = 0; i < layers; i++) begin
         layer.first_layer     = (i == 0);
         layer.last_layer      = (i == layers - 1);
         layer.potential_et    = pick_amount(100 * MM);
         layer.interception_et = pick_amount(8 * MM);
         layer.depression_et   = pick_amount(8 * MM);
         layer.plant_et        = pick_amount(30 * MM);
         layer.soil_temp       = pick_temp();
         layer.layer_water     = pick_amount(60 * MM);
         layer.field_capacity  = pick_amount(60 * MM);
         if (kind != CELL_WELL) begin
            layer.first_layer = 1'($urandom_range(0, 1));
            layer.last_layer  = 1'($urandom_range(0, 1));
         end
         if (kind == CELL_NOISE) begin
            layer.potential_et    = $urandom;
            layer.interception_et = $urandom;
            layer.depression_et   = $urandom;
            layer.plant_et        = $urandom;
            layer.soil_temp       = $urandom;
            layer.layer_water     = $urandom;
            layer.field_capacity  = $urandom;
         end
         send_layer(layer);
      end
   endtask

   task automatic test_directed_layers();
      stall_mode = STALL_NONE;
      gap_max    = 0;
      // layers before any cell has opened
      send_layer(make_layer(1'b0, 1'b0, 0, 0, 0, 0, 0, 5 * MM, 10 * MM));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, -3 * MM, 10 * MM));
      // deficit sums saturating both ways
      send_layer(make_layer(1'b1, 1'b0, VMAX, VMIN, 0, 0, MM, VMAX, VMAX));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, 7 * MM, 3 * MM));
      send_layer(make_layer(1'b1, 1'b1, VMIN, VMAX, VMAX, VMAX, VMAX, VMIN, VMIN));
      // frozen cells, temperature at the threshold and far below it
      send_layer(make_layer(1'b1, 1'b0, 10 * MM, 0, 0, 0, 0, 5 * MM, 10 * MM));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, 8 * MM, 2 * MM));
      send_layer(make_layer(1'b1, 1'b1, 10 * MM, 0, 0, 0, VMIN, 5 * MM, 10 * MM));
      // linear share, zero and negative water, zero and negative capacity
      send_layer(make_layer(1'b1, 1'b0, 20 * MM, 2 * MM, 3 * MM, 5 * MM, MM,
                            4 * MM, 8 * MM));
      send_layer(make_layer(1'b0, 1'b0, 0, 0, 0, 0, 0, 0, 10 * MM));
      send_layer(make_layer(1'b0, 1'b0, 0, 0, 0, 0, 0, -2 * MM, 10 * MM));
      send_layer(make_layer(1'b0, 1'b0, 0, 0, 0, 0, 0, 3 * MM, 0));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, MM, -MM));
      // truncation of the quotient, water equal to capacity
      send_layer(make_layer(1'b1, 1'b0, 7, 0, 0, 0, MM, 3, 11));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, 11, 11));
      // deficit update and cell total hitting the rails
      send_layer(make_layer(1'b1, 1'b0, VMAX, 0, 0, 0, VMAX, VMIN, 0));
      send_layer(make_layer(1'b0, 1'b0, 0, 0, 0, 0, 0, VMIN, 5 * MM));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, VMAX, MM));
      send_layer(make_layer(1'b1, 1'b1, VMIN, 1, 0, 0, MM, MM, MM));
      send_layer(make_layer(1'b1, 1'b0, 0, 0, VMIN, 0, MM, 30 * MM, 60 * MM));
      send_layer(make_layer(1'b1, 1'b0, 0, 0, 0, VMIN, MM, 30 * MM, 60 * MM));
      send_layer(make_layer(1'b0, 1'b1, 0, 0, 0, 0, 0, VMAX - 1, VMAX));
   endtask

   task automatic test_frost_threshold();
      logic signed [DW-1:0] settings [6];
      settings   = '{VMIN, VMAX, 0, -MM, pick_temp(), pick_temp()};
      stall_mode = STALL_PATTERN;
      gap_max    = 12;
      foreach (settings[k]) begin
         write_threshold(settings[k]);
         // temperature exactly on the threshold freezes the cell
         send_layer(make_layer(1'b1, 1'b1, 9 * MM, 0, 0, 0, settings[k], MM, 2 * MM));
         repeat (6) random_cell(CELL_WELL);
      end
   endtask

   task automatic test_output_holdoff();
      stall_mode   = STALL_RANDOM;
      gap_max      = 0;
      hold_request = 1'b1;
      repeat (10) random_cell(CELL_WELL);
   endtask

   task automatic test_random_cells();
      int unsigned draw;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0:       stall_mode = STALL_NONE;
            1:       stall_mode = STALL_RANDOM;
            default: stall_mode = STALL_PATTERN;
         endcase
         case ($urandom_range(0, 3))
            0:       gap_max = 0;
            1:       gap_max = 4;
            2:       gap_max = 12;
            default: gap_max = 45;
         endcase
         if ($urandom_range(0, 5) == 0) begin
            stall_mode = STALL_NONE;
            gap_max    = 0;
         end
         if ($urandom_range(0, 3) == 0) write_threshold(pick_temp());
         repeat (8) begin
            draw = $urandom_range(0, 9);
            if (draw < 8)
               random_cell(CELL_WELL);
            else if (draw == 8)
               random_cell(CELL_BROKEN);
            else
               random_cell(CELL_NOISE);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_layers();
      test_frost_threshold();
      test_output_holdoff();
      test_random_cells();
      settle_block();
      if (failures == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/soilevap_pkg.sv
design/soil_evaporation_linear.sv
test/tb_top.sv
